// ===== rtl/igcr_pkg.sv =====
// ----------------------------------------------------------------------------
// igcr_pkg: shared definitions of the idle-gap frame receiver
// Codes, register indexes, reset values and the byte-wise CRC-16 step.
// ----------------------------------------------------------------------------
package igcr_pkg;

  // default geometry
  localparam int unsigned ChannelsDef  = 2;
  localparam int unsigned RingDepthDef = 32;

  // register map
  localparam logic CfgGapTicks = 1'b0;
  localparam logic CfgFrameLen = 1'b1;

  localparam logic [15:0] GapTicksReset = 16'd4;
  localparam logic [5:0]  FrameLenReset = 6'd32;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } igcr_cmd_e;

  typedef enum logic {
    KIND_STATUS  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } igcr_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAN = 2'd1,
    ST_FULL     = 2'd2
  } igcr_status_e;

  // one byte of the reflected crc-16, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/igcr_in_if.sv =====
// ----------------------------------------------------------------------------
// igcr_in_if: input item channel
// Valid/ready handshake carrying command, channel and data.
// ----------------------------------------------------------------------------
interface igcr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] channel;
  logic [7:0] data;

  modport source (output valid, command, channel, data, input ready);
  modport sink (input valid, command, channel, data, output ready);
endinterface

// ===== rtl/igcr_out_if.sv =====
// ----------------------------------------------------------------------------
// igcr_out_if: result item channel
// Valid/ready handshake carrying status and payload results.
// ----------------------------------------------------------------------------
interface igcr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] out_channel;
  logic [7:0] payload_byte;
  logic       last;
  logic [1:0] status;
  logic       overflow_seen;

  modport source (output valid, kind, out_channel, payload_byte, last, status,
                  overflow_seen, input ready);
  modport sink (input valid, kind, out_channel, payload_byte, last, status,
                overflow_seen, output ready);
endinterface

// ===== rtl/idle_gap_crc_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// idle_gap_crc_frame_receiver_core: multi-channel idle-gap frame receiver
// Byte items fill per-channel rings; tick items close frames after an idle
// gap and release payload bytes of frames whose CRC-16 checks out.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : input items; command 0 stores a byte on a channel, command 1 is
//           a time tick that ages every channel's idle counter
//   out_o : result items; one status item per byte item, payload items of
//           good frames after a tick, the last byte of a frame flagged
//   cfg   : cfg_we_i writes gap_ticks (index 0) or frame_buffer_len (index 1)
// Flow:
//   byte items go at one per cycle while the result register is free; the
//   status item is visible the cycle after its byte item is taken
//   a tick item visits each channel in turn; a closing channel with more
//   than two drained bytes streams them through the CRC, checks the last
//   two against it and, on a match, re-reads each payload byte from the
//   ring memory through its single read port
// Reset: pointers, idle counters and overflow flags clear, registers take
//   their defaults; ring contents are undefined until written
// Stalls: a held result item stops the walk; no input item is taken until
//   all results of the current one are out
// ----------------------------------------------------------------------------
module idle_gap_crc_frame_receiver_core
  import igcr_pkg::*;
#(
  parameter int unsigned CHANNELS   = ChannelsDef,
  parameter int unsigned RING_DEPTH = RingDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  igcr_in_if.sink     in_i,
  igcr_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned PW    = $clog2(RING_DEPTH);
  localparam int unsigned CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned Depth = CHANNELS * RING_DEPTH;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TICK  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_CHECK = 6'b001000,
    S_ERD   = 6'b010000,
    S_EWAIT = 6'b100000
  } state_e;

  // wrap helpers
  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p, input logic [5:0] off);
    logic [6:0] s;
    s = 7'(p) + 7'(off);
    if (s >= 7'(RING_DEPTH)) begin
      s = s - 7'(RING_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic [CHW-1:0] c, input logic [PW-1:0] p);
    return AW'(AW'(c) * AW'(RING_DEPTH)) + AW'(p);
  endfunction

  state_e         state_q, state_d;
  logic [15:0]    gap_q;
  logic [5:0]     fbl_q;
  logic [PW-1:0]  wp_q  [CHANNELS];
  logic [PW-1:0]  rp_q  [CHANNELS];
  logic [15:0]    idle_q [CHANNELS];
  logic           ovf_q [CHANNELS];
  logic [CHW-1:0] cidx_q;
  logic [5:0]     n_q, issue_q, rpos_q, eidx_q;
  logic [PW-1:0]  rps_q;
  logic           rvalid_q;
  logic [15:0]    crc_q;
  logic [7:0]     lo_q, hi_q;

  logic           out_valid_q;
  logic           out_kind_q, out_last_q, out_ovf_q;
  logic [2:0]     out_ch_q;
  logic [7:0]     out_byte_q;
  logic [1:0]     out_st_q;

  logic           out_free, in_acc, bad_ch, full, last_chan, issuing, emit_load;
  logic [CHW-1:0] ich;
  logic [PW-1:0]  wp_nxt;
  logic [6:0]     fill;
  logic [5:0]     n_new, rd_off;
  logic [16:0]    idle_inc;
  logic [7:0]     rdata;
  logic [AW-1:0]  raddr;

  // handshake
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc = in_i.valid && in_i.ready;

  // byte item decode
  assign bad_ch = in_i.channel >= 3'(CHANNELS);
  assign ich    = in_i.channel[CHW-1:0];
  assign wp_nxt = ring_inc(wp_q[ich]);
  assign full   = (wp_nxt == rp_q[ich]);

  // tick decode for the channel in hand
  assign last_chan = (cidx_q == CHW'(CHANNELS - 1));
  assign idle_inc  = {1'b0, idle_q[cidx_q]} + 17'd1;
  assign fill      = 7'(wp_q[cidx_q]) + ((wp_q[cidx_q] < rp_q[cidx_q]) ? 7'(RING_DEPTH) : 7'd0)
                     - 7'(rp_q[cidx_q]);
  assign n_new     = (7'(fbl_q) < fill) ? fbl_q : fill[5:0];

  // ring read address
  assign issuing   = (state_q == S_SCAN) && (issue_q < n_q);
  assign rd_off    = (state_q == S_SCAN) ? issue_q : eidx_q;
  assign raddr     = mem_addr(cidx_q, ring_add(rps_q, rd_off));
  assign emit_load = (state_q == S_EWAIT) && out_free;

  igcr_ring_mem #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_i.command == CMD_BYTE) && !bad_ch && !full),
    .waddr_i (mem_addr(ich, wp_q[ich])),
    .wdata_i (in_i.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.command == CMD_TICK)) state_d = S_TICK;
      end
      S_TICK: begin
        if ((idle_inc >= {1'b0, gap_q}) && (n_new > 6'd2)) state_d = S_SCAN;
        else if (last_chan) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (rvalid_q && (rpos_q == n_q - 6'd1)) state_d = S_CHECK;
      end
      S_CHECK: begin
        if ({hi_q, lo_q} == crc_q) state_d = S_ERD;
        else if (last_chan) state_d = S_IDLE;
        else state_d = S_TICK;
      end
      S_ERD: begin
        state_d = S_EWAIT;
      end
      S_EWAIT: begin
        if (emit_load) begin
          if (eidx_q == n_q - 6'd3) state_d = last_chan ? S_IDLE : S_TICK;
          else state_d = S_ERD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      gap_q    <= GapTicksReset;
      fbl_q    <= FrameLenReset;
      cidx_q   <= '0;
      rvalid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c]   <= '0;
        rp_q[c]   <= '0;
        idle_q[c] <= '0;
        ovf_q[c]  <= 1'b0;
      end
    end else begin
      state_q  <= state_d;
      rvalid_q <= issuing;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgGapTicks) gap_q <= cfg_data_i;
        else fbl_q <= cfg_data_i[5:0];
      end
      // byte item
      if (in_acc && (in_i.command == CMD_BYTE) && !bad_ch) begin
        if (full) begin
          ovf_q[ich] <= 1'b1;
        end else begin
          wp_q[ich]   <= wp_nxt;
          idle_q[ich] <= '0;
        end
      end
      if (in_acc && (in_i.command == CMD_TICK)) cidx_q <= '0;
      // idle counter and drain decision
      if (state_q == S_TICK) begin
        if (idle_inc < {1'b0, gap_q}) begin
          idle_q[cidx_q] <= idle_inc[15:0];
        end else begin
          idle_q[cidx_q] <= '0;
          rp_q[cidx_q]   <= ring_add(rp_q[cidx_q], n_new);
        end
        if (state_d == S_TICK) cidx_q <= cidx_q + CHW'(1);
      end
      if ((state_q == S_CHECK || state_q == S_EWAIT) && state_d == S_TICK) begin
        cidx_q <= cidx_q + CHW'(1);
      end
    end
  end

  // frame walk registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_TICK) begin
      n_q     <= n_new;
      rps_q   <= rp_q[cidx_q];
      issue_q <= '0;
      crc_q   <= CrcInit;
    end
    if (issuing) issue_q <= issue_q + 6'd1;
    rpos_q <= issue_q;
    if ((state_q == S_SCAN) && rvalid_q) begin
      if (rpos_q < n_q - 6'd2) crc_q <= crc_byte(crc_q, rdata);
      else if (rpos_q == n_q - 6'd2) lo_q <= rdata;
      else hi_q <= rdata;
    end
    if (state_q == S_CHECK) eidx_q <= '0;
    if (emit_load) eidx_q <= eidx_q + 6'd1;
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && (in_i.command == CMD_BYTE)) begin
      out_valid_q <= 1'b1;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.command == CMD_BYTE)) begin
      out_kind_q <= KIND_STATUS;
      out_ch_q   <= in_i.channel;
      out_byte_q <= '0;
      out_last_q <= 1'b0;
      if (bad_ch) begin
        out_st_q  <= ST_BAD_CHAN;
        out_ovf_q <= 1'b0;
      end else if (full) begin
        out_st_q  <= ST_FULL;
        out_ovf_q <= 1'b1;
      end else begin
        out_st_q  <= ST_OK;
        out_ovf_q <= ovf_q[ich];
      end
    end else if (emit_load) begin
      out_kind_q <= KIND_PAYLOAD;
      out_ch_q   <= 3'(cidx_q);
      out_byte_q <= rdata;
      out_last_q <= (eidx_q == n_q - 6'd3);
      out_st_q   <= ST_OK;
      out_ovf_q  <= ovf_q[cidx_q];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_kind_q;
  assign out_o.out_channel   = out_ch_q;
  assign out_o.payload_byte  = out_byte_q;
  assign out_o.last          = out_last_q;
  assign out_o.status        = out_st_q;
  assign out_o.overflow_seen = out_ovf_q;

endmodule

// ===== rtl/igcr_ring_mem.sv =====
// ----------------------------------------------------------------------------
// igcr_ring_mem: ring byte store of all channels
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module igcr_ring_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/idle_gap_crc_frame_receiver_core_tb.sv =====
// ----------------------------------------------------------------------------
// idle_gap_crc_frame_receiver_core_tb: self-checking bench of the receiver
// Drives byte and tick items with random gaps, predicts every status and
// payload item from a behavioural copy of the rings and compares in order.
// ----------------------------------------------------------------------------
module idle_gap_crc_frame_receiver_core_tb;
  import igcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumChan = 2;
  localparam int unsigned Depth   = 32;

  typedef struct packed {
    igcr_kind_e   kind;
    logic [2:0]   chan;
    logic [7:0]   pbyte;
    logic         last;
    igcr_status_e status;
    logic         ovf;
  } rx_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [15:0] cfg_data = '0;

  igcr_in_if  in_ch();
  igcr_out_if out_ch();

  idle_gap_crc_frame_receiver_core u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch.sink),
    .out_o     (out_ch.source),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  ring_mem [NumChan][Depth];
  logic [4:0]  wr_ptr [NumChan];
  logic [4:0]  rd_ptr [NumChan];
  logic [15:0] idle_cnt [NumChan];
  logic        ovf_flag [NumChan];
  logic [15:0] gap_reg;
  logic [5:0]  flen_reg;

  rx_result_t expected_q[$];
  int  n_errors = 0;
  int  n_sent = 0;
  bit  calm = 1'b0;

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic logic [15:0] modbus_crc(input logic [7:0] buf_b[$], input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c ^= {8'h00, buf_b[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  // work out the results of one item
  task automatic predict_item(input igcr_cmd_e cmd, input logic [2:0] ch,
                              input logic [7:0] data);
    rx_result_t r;
    logic [4:0] nxt;
    logic [7:0] drained[$];
    int n;
    if (cmd == CMD_BYTE) begin
      r = '{KIND_STATUS, ch, 8'h00, 1'b0, ST_OK, 1'b0};
      if (ch >= NumChan) begin
        r.status = ST_BAD_CHAN;
      end else begin
        nxt = wr_ptr[ch] + 5'd1;
        if (nxt == rd_ptr[ch]) begin
          ovf_flag[ch] = 1'b1;
          r.status = ST_FULL;
        end else begin
          ring_mem[ch][wr_ptr[ch]] = data;
          wr_ptr[ch] = nxt;
          idle_cnt[ch] = '0;
        end
        r.ovf = ovf_flag[ch];
      end
      expected_q.push_back(r);
    end else begin
      for (int c = 0; c < NumChan; c++) begin
        if (32'(idle_cnt[c]) + 1 < 32'(gap_reg)) begin
          idle_cnt[c]++;
          continue;
        end
        idle_cnt[c] = '0;
        drained.delete();
        while (drained.size() < flen_reg && rd_ptr[c] != wr_ptr[c]) begin
          drained.push_back(ring_mem[c][rd_ptr[c]]);
          rd_ptr[c]++;
        end
        n = drained.size();
        if (n <= 2) continue;
        if ({drained[n-1], drained[n-2]} != modbus_crc(drained, n - 2)) continue;
        for (int i = 0; i < n - 2; i++) begin
          r = '{KIND_PAYLOAD, 3'(c), drained[i], (i == n - 3), ST_OK, ovf_flag[c]};
          expected_q.push_back(r);
        end
      end
    end
  endtask

  // send one item and predict it once taken
  task automatic send_item(input igcr_cmd_e cmd, input logic [2:0] ch,
                           input logic [7:0] data);
    while (!calm && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.channel <= ch;
    in_ch.data    <= data;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(cmd, ch, data);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    wait_drained();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgGapTicks) gap_reg = val; else flen_reg = val[5:0];
  endtask

  // send a frame with a good crc, optionally corrupted
  task automatic send_frame(input int ch, input int len, input bit corrupt);
    logic [7:0] body[$];
    logic [15:0] crc;
    for (int i = 0; i < len; i++) body.push_back(8'($urandom));
    crc = modbus_crc(body, len);
    if (corrupt) crc ^= 16'h0001 << $urandom_range(15);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    foreach (body[i]) send_item(CMD_BYTE, 3'(ch), body[i]);
  endtask

  task automatic close_gap();
    for (int i = 0; i < ((gap_reg == 16'd0) ? 1 : int'(gap_reg)); i++)
      send_item(CMD_TICK, 3'($urandom), 8'($urandom));
  endtask

  // result checker with random stall
  always @(posedge clk_i) begin
    rx_result_t got;
    if (out_ch.valid && out_ch.ready) begin
      got = '{igcr_kind_e'(out_ch.kind), out_ch.out_channel, out_ch.payload_byte,
              out_ch.last, igcr_status_e'(out_ch.status), out_ch.overflow_seen};
      if (expected_q.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        if (got !== expected_q[0])
          report_mismatch($sformatf("got %p exp %p", got, expected_q[0]));
        void'(expected_q.pop_front());
      end
    end
    out_ch.ready <= calm || ($urandom_range(99) >= 15);
  end

  task automatic test_directed();
    send_item(CMD_BYTE, 3'd7, 8'hFF);
    send_item(CMD_BYTE, 3'd2, 8'h00);
    send_frame(0, 1, 0);
    send_frame(1, 4, 0);
    close_gap();
    send_frame(0, 3, 1);
    send_item(CMD_BYTE, 3'd1, 8'h00);
    close_gap();
    send_item(CMD_BYTE, 3'd0, 8'hAA);
    close_gap();
  endtask

  task automatic test_overflow();
    calm = 1'b1;
    for (int i = 0; i < 33; i++) send_item(CMD_BYTE, 3'd1, 8'($urandom));
    close_gap();
    close_gap();
    calm = 1'b0;
  endtask

  task automatic test_config_extremes();
    write_reg(CfgFrameLen, 16'd3);
    write_reg(CfgGapTicks, 16'd1);
    send_frame(0, 1, 0);
    close_gap();
    send_frame(1, 3, 0);
    close_gap(); close_gap(); close_gap();
    write_reg(CfgFrameLen, 16'd63);
    write_reg(CfgGapTicks, 16'd0);
    send_frame(0, 29, 0);
    close_gap();
    write_reg(CfgGapTicks, 16'hFFFF);
    send_item(CMD_BYTE, 3'd0, 8'h55);
    send_item(CMD_TICK, 3'd0, 8'h00);
    write_reg(CfgGapTicks, 16'd0);
    close_gap();
    write_reg(CfgFrameLen, 16'd32);
    write_reg(CfgGapTicks, 16'd3);
  endtask

  task automatic test_random();
    while (n_sent < 125) begin
      case ($urandom_range(9))
        0: begin
          send_item(igcr_cmd_e'($urandom_range(1)), 3'($urandom), 8'($urandom));
        end
        1: begin
          send_frame($urandom_range(1), $urandom_range(1, 8), 1);
        end
        default: begin
          send_frame($urandom_range(1), $urandom_range(1, 10), 0);
          if ($urandom_range(1)) close_gap();
        end
      endcase
      if ($urandom_range(3) == 0) wait_drained();
    end
    close_gap();
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.command = 1'b0; in_ch.channel = '0; in_ch.data = '0;
    out_ch.ready = 1'b0;
    gap_reg = GapTicksReset;
    flen_reg = FrameLenReset;
    for (int c = 0; c < NumChan; c++) begin
      wr_ptr[c] = '0; rd_ptr[c] = '0; idle_cnt[c] = '0; ovf_flag[c] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_overflow();
    test_config_extremes();
    test_random();
    wait_drained();
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/igcr_pkg.sv
rtl/igcr_in_if.sv
rtl/igcr_out_if.sv
rtl/igcr_ring_mem.sv
rtl/idle_gap_crc_frame_receiver_core.sv
tb/idle_gap_crc_frame_receiver_core_tb.sv
